@@ sv/pss_pkg.sv @@
package pss_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int RES_BITS       = VALUE_BITS - 1;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;
  localparam int QDEPTH         = 4;
  localparam int QPTR_BITS      = 2;
  localparam int QLEVEL_BITS    = 3;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [RES_BITS-1:0]          res_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam res_t   RES_MAX   = {RES_BITS{1'b1}};

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_LAST_INDEX = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_METHOD          = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_RESIDUAL  = 2'd2;

  localparam logic METHOD_JACOBI       = 1'b0;
  localparam logic METHOD_GAUSS_SEIDEL = 1'b1;

  typedef struct packed {
    value_t grid_value;
    value_t forcing;
  } sample_t;

  typedef struct packed {
    value_t new_value;
    res_t   residual_max;
    logic   last;
  } result_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic second;
    logic last;
    logic first_col;
    logic clear;
  } pt_flags_t;

  typedef struct packed {
    value_t right;
    value_t up_old;
    value_t up_new;
    value_t forcing;
    value_t center0;
  } ls_rd_t;

  typedef struct packed {
    logic    first;
    logic    second;
    result_t a;
    result_t b;
  } push_t;

endpackage

@@ sv/poisson_stencil_sweep.sv @@
// Five-point Poisson stencil, one sweep per pass of the grid.
// Input channel (sample_valid/sample_stall/sample): grid points in raster
// order, each with its forcing term, signed Q4.28. Output channel
// (result_valid/result_stall/result): updated points in raster order with
// the running maximum of the absolute change and a flag on the final point.
// The transfer of point (r,c) yields point (r-1,c); on the last row it also
// yields (r,c) itself, so row 0 gives nothing and the last row gives two.
// Each result passes the pipeline stages into the output queue and is
// offered from there once it has been written.
// Throughput: one point per cycle while the queue has room; on the last
// row each point gives two results, paced by the one-result-per-cycle
// output port. A four-entry output queue decouples the channels: input
// is stalled only when fewer than two queue entries are free, so an
// output stall reaches the input as the queue fills and no result is dropped.
// Reset clears the row and column counters, the running maximum, the
// pipeline and the queue, and loads the register defaults (last index 8,
// Jacobi, residual on). The line stores are not cleared and need no sweep.
// Configuration writes take effect at once; write only while idle.
module poisson_stencil_sweep #(
  parameter int MAX_ROW_POINTS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  pss_pkg::sample_t                        sample,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output pss_pkg::result_t                        result,
  input  logic                                    cfg_write,
  input  logic [pss_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [pss_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
  import pss_pkg::*;

  localparam int CW = $clog2(MAX_ROW_POINTS);
  localparam int IW = (CW > CFG_DATA_BITS) ? CW : CFG_DATA_BITS;
  localparam logic [CW-1:0] L_RESET =
    CW'((MAX_ROW_POINTS - 1 < 8) ? MAX_ROW_POINTS - 1 : 8);
  localparam logic [IW-1:0] L_MAX = IW'(MAX_ROW_POINTS - 1);
  localparam logic [IW-1:0] L_MIN = IW'(2);

  logic [CW-1:0] grid_last_index;
  logic          method;
  logic          track_residual;
  logic [IW-1:0] cfg_len;
  logic [CW-1:0] grid_last_index_next;

  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count;

  logic adv;
  logic accept;
  logic row_end;
  logic grid_end;
  pt_flags_t flags;

  ls_rd_t rd;
  logic nr_write;
  logic [CW-1:0] nr_addr;
  value_t nr_data;
  push_t push;
  logic [QLEVEL_BITS-1:0] level;

  assign adv          = (level <= QLEVEL_BITS'(QDEPTH - 2));
  assign sample_stall = !adv;
  assign accept       = sample_valid && !sample_stall;

  assign cfg_len = IW'(cfg_data);
  always_comb begin
    priority if (cfg_len < L_MIN) begin
      grid_last_index_next = CW'(L_MIN);
    end else if (cfg_len > L_MAX) begin
      grid_last_index_next = CW'(L_MAX);
    end else begin
      grid_last_index_next = cfg_len[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_last_index <= L_RESET;
      method          <= METHOD_JACOBI;
      track_residual  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_LAST_INDEX: grid_last_index <= grid_last_index_next;
        REG_METHOD:          method <= cfg_data[0];
        REG_TRACK_RESIDUAL:  track_residual <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign row_end  = (column_count >= grid_last_index);
  assign grid_end = (row_count >= grid_last_index);

  assign flags.emit      = (row_count != '0);
  assign flags.interior  = (row_count >= CW'(2)) && (column_count != '0)
                         && (column_count < grid_last_index);
  assign flags.second    = grid_end && (row_count != '0);
  assign flags.last      = row_end;
  assign flags.first_col = (column_count == '0);
  assign flags.clear     = (row_count == '0) && (column_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= grid_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  pss_line_store #(.CW(CW)) u_line_store (
    .clk      (clk),
    .accept   (accept),
    .bank     (row_count[0]),
    .col      (column_count),
    .sample   (sample),
    .nr_write (nr_write),
    .nr_addr  (nr_addr),
    .nr_data  (nr_data),
    .rd       (rd)
  );

  pss_stencil_pipe #(.CW(CW)) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .accept         (accept),
    .flags          (flags),
    .col            (column_count),
    .cur            (sample.grid_value),
    .rd             (rd),
    .method         (method),
    .track_residual (track_residual),
    .nr_write       (nr_write),
    .nr_addr        (nr_addr),
    .nr_data        (nr_data),
    .push           (push)
  );

  pss_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .level        (level)
  );

`ifndef SYNTHESIS
  a_second_has_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("pass-through result without updated result");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QLEVEL_BITS'(QDEPTH))
    else $error("output queue overflow");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> column_count == '0)
    else $error("column counter did not wrap at row end");
`endif

endmodule

@@ sv/pss_line_store.sv @@
module pss_line_store #(
  parameter int CW = 10
) (
  input  logic              clk,
  input  logic              accept,
  input  logic              bank,
  input  logic [CW-1:0]     col,
  input  pss_pkg::sample_t  sample,
  input  logic              nr_write,
  input  logic [CW-1:0]     nr_addr,
  input  pss_pkg::value_t   nr_data,
  output pss_pkg::ls_rd_t   rd
);
  import pss_pkg::*;

  localparam int DEPTH = 1 << CW;

  value_t old_rows [0:2*DEPTH-1];
  value_t new_row [0:DEPTH-1];
  value_t forcing_row [0:DEPTH-1];
  value_t col0;

  value_t rd_right;
  value_t rd_up_old;
  value_t rd_up_new;
  value_t rd_forcing;
  value_t rd_center0;

  logic [CW-1:0] col_inc;

  assign col_inc = col + 1'b1;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_right   <= old_rows[{~bank, col_inc}];
      rd_up_old  <= old_rows[{bank, col}];
      rd_forcing <= forcing_row[col];
      rd_center0 <= col0;
      old_rows[{bank, col}] <= sample.grid_value;
      forcing_row[col]      <= sample.forcing;
      if (col == '0) begin
        col0 <= sample.grid_value;
      end
    end
  end

  // forward a same-edge update of the entry being read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (nr_write && (nr_addr == col)) begin
        rd_up_new <= nr_data;
      end else begin
        rd_up_new <= new_row[col];
      end
    end
    if (nr_write) begin
      new_row[nr_addr] <= nr_data;
    end
  end

  assign rd = '{right: rd_right, up_old: rd_up_old, up_new: rd_up_new,
                forcing: rd_forcing, center0: rd_center0};

endmodule

@@ sv/pss_stencil_pipe.sv @@
module pss_stencil_pipe #(
  parameter int CW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                accept,
  input  pss_pkg::pt_flags_t  flags,
  input  logic [CW-1:0]       col,
  input  pss_pkg::value_t     cur,
  input  pss_pkg::ls_rd_t     rd,
  input  logic                method,
  input  logic                track_residual,
  output logic                nr_write,
  output logic [CW-1:0]       nr_addr,
  output pss_pkg::value_t     nr_data,
  output pss_pkg::push_t      push
);
  import pss_pkg::*;

  logic v1, v2, v3, v4, v5;
  pt_flags_t f1, f2, f3, f4, f5;
  logic [CW-1:0] c1, c2, c3;
  value_t cur1, cur2, cur3, cur4, cur5;
  value_t center2, center3, center4;
  value_t left2, left3;
  value_t frc2;
  value_t res4, res5;
  logic signed [VALUE_BITS+1:0] u2;
  logic signed [VALUE_BITS+3:0] t3;
  res_t d5;
  res_t running_max;
  res_t running_max_next;

  value_t win_center, win_left, prev_res;

  value_t center1, up1;
  logic signed [VALUE_BITS+1:0] u1;
  logic signed [VALUE_BITS+3:0] t2;
  value_t left_sel;
  logic signed [VALUE_BITS+4:0] s3;
  logic signed [VALUE_BITS+2:0] q3;
  value_t res3;
  logic signed [VALUE_BITS:0] diff4;
  logic [VALUE_BITS:0] mag4;
  res_t d4;

  assign center1 = f1.first_col ? rd.center0 : win_center;
  assign up1     = (method == METHOD_GAUSS_SEIDEL) ? rd.up_new : rd.up_old;
  assign u1      = (VALUE_BITS+2)'(up1) + (VALUE_BITS+2)'(rd.right)
                 + (VALUE_BITS+2)'(cur1);

  assign t2 = (VALUE_BITS+4)'(u2) + ((VALUE_BITS+4)'(frc2) <<< 2);

  assign left_sel = (method == METHOD_GAUSS_SEIDEL) ? prev_res : left3;
  assign s3       = (VALUE_BITS+5)'(t3) + (VALUE_BITS+5)'(left_sel);
  assign q3       = s3[VALUE_BITS+4:2];

  always_comb begin
    if (!f3.interior) begin
      res3 = center3;
    end else if (q3 > (VALUE_BITS+3)'(VALUE_MAX)) begin
      res3 = VALUE_MAX;
    end else if (q3 < (VALUE_BITS+3)'(VALUE_MIN)) begin
      res3 = VALUE_MIN;
    end else begin
      res3 = q3[VALUE_BITS-1:0];
    end
  end

  assign diff4 = (VALUE_BITS+1)'(center4) - (VALUE_BITS+1)'(res4);
  assign mag4  = diff4[VALUE_BITS] ? (VALUE_BITS+1)'(-diff4) : (VALUE_BITS+1)'(diff4);
  assign d4    = (mag4 > (VALUE_BITS+1)'(RES_MAX)) ? RES_MAX : mag4[RES_BITS-1:0];

  always_comb begin
    priority if (f5.clear) begin
      running_max_next = '0;
    end else if (f5.interior && track_residual && (d5 > running_max)) begin
      running_max_next = d5;
    end else begin
      running_max_next = running_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      running_max <= '0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (v5) begin
        running_max <= running_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1      <= flags;
      c1      <= col;
      cur1    <= cur;
      f2      <= f1;
      c2      <= c1;
      cur2    <= cur1;
      center2 <= center1;
      left2   <= win_left;
      u2      <= u1;
      frc2    <= rd.forcing;
      f3      <= f2;
      c3      <= c2;
      cur3    <= cur2;
      center3 <= center2;
      left3   <= left2;
      t3      <= t2;
      f4      <= f3;
      cur4    <= cur3;
      center4 <= center3;
      res4    <= res3;
      f5      <= f4;
      cur5    <= cur4;
      res5    <= res4;
      d5      <= d4;
      if (v1) begin
        win_left   <= center1;
        win_center <= rd.right;
      end
      if (v3) begin
        prev_res <= res3;
      end
    end
  end

  assign nr_write = adv && v3 && f3.emit;
  assign nr_addr  = c3;
  assign nr_data  = res3;

  assign push.first  = adv && v5 && f5.emit;
  assign push.second = adv && v5 && f5.second;
  assign push.a = '{new_value: res5, residual_max: running_max_next, last: 1'b0};
  assign push.b = '{new_value: cur5, residual_max: running_max_next, last: f5.last};

endmodule

@@ sv/pss_out_queue.sv @@
module pss_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  pss_pkg::push_t                      push,
  input  logic                                result_stall,
  output logic                                result_valid,
  output pss_pkg::result_t                    result,
  output logic [pss_pkg::QLEVEL_BITS-1:0]     level
);
  import pss_pkg::*;

  result_t entries [0:QDEPTH-1];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS-1:0] wptr_b;
  logic [QLEVEL_BITS-1:0] n_push;
  logic pop;

  assign result_valid = (level != '0);
  assign result       = entries[rptr];
  assign pop          = result_valid && !result_stall;
  assign n_push       = QLEVEL_BITS'(push.first) + QLEVEL_BITS'(push.second);
  assign wptr_b       = push.first ? wptr + 1'b1 : wptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + n_push[QPTR_BITS-1:0];
      level <= level + n_push - QLEVEL_BITS'(pop);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wptr] <= push.a;
    end
    if (push.second) begin
      entries[wptr_b] <= push.b;
    end
  end

endmodule

@@ tb/tb_poisson_stencil_sweep.sv @@
module tb_poisson_stencil_sweep;
  timeunit 1ns;
  timeprecision 1ps;
  import pss_pkg::*;

  localparam int unsigned ROW_POINTS = 1024;
  localparam int unsigned MIN_LAST_INDEX = 2;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int RANDOM_POINTS = 340;
  localparam int CALM_POINTS = 250;
  localparam int WIDE_POINTS = 200;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  class sweep_scoreboard;
    value_t old_rows[2*ROW_POINTS];
    value_t new_row[ROW_POINTS];
    value_t forcing_row[ROW_POINTS];
    int unsigned last_index;
    logic method_sel;
    logic track;
    int unsigned row_count;
    int unsigned col_count;
    res_t running_max;
    result_t expected_q[$];
    int mismatches;

    function new();
      last_index = 8;
      method_sel = METHOD_JACOBI;
      track = 1'b1;
      row_count = 0;
      col_count = 0;
      running_max = '0;
      mismatches = 0;
    endfunction

    function void write_config(logic [CFG_INDEX_BITS-1:0] index,
                               logic [CFG_DATA_BITS-1:0] data);
      case (index)
        REG_GRID_LAST_INDEX: last_index = (data < MIN_LAST_INDEX) ? MIN_LAST_INDEX : data;
        REG_METHOD: method_sel = data[0];
        REG_TRACK_RESIDUAL: track = data[0];
        default: ;
      endcase
    endfunction

    function bit at_start();
      return row_count == 0 && col_count == 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_point(sample_t pt);
      int unsigned r, c, cur_bank, prev_bank, lim;
      bit row_end, grid_end, gauss;
      value_t center, upv, leftv, rightv, upd;
      longint sum, q, d;
      result_t exp_res;
      lim = last_index;
      r = row_count;
      c = col_count;
      row_end = c >= lim;
      grid_end = r >= lim;
      gauss = method_sel == METHOD_GAUSS_SEIDEL;
      if (c > ROW_POINTS - 1) c = ROW_POINTS - 1;
      cur_bank = (r & 1) * ROW_POINTS;
      prev_bank = ((r + 1) & 1) * ROW_POINTS;
      if (r == 0 && c == 0) running_max = '0;
      if (r >= 1) begin
        center = old_rows[prev_bank + c];
        upd = center;
        if (r >= 2 && c >= 1 && c < lim) begin
          upv = gauss ? new_row[c] : old_rows[cur_bank + c];
          leftv = gauss ? new_row[c-1] : old_rows[prev_bank + c - 1];
          rightv = old_rows[prev_bank + c + 1];
          sum = longint'(upv) + longint'(leftv) + longint'(rightv) + longint'(pt.grid_value);
          q = (sum >>> 2) + longint'(forcing_row[c]);
          if (q > longint'(VALUE_MAX)) upd = VALUE_MAX;
          else if (q < longint'(VALUE_MIN)) upd = VALUE_MIN;
          else upd = value_t'(q);
          if (track) begin
            d = longint'(center) - longint'(upd);
            if (d < 0) d = -d;
            if (d > longint'(RES_MAX)) d = longint'(RES_MAX);
            if (d > longint'(running_max)) running_max = res_t'(d);
          end
        end
        new_row[c] = upd;
        exp_res.new_value = upd;
        exp_res.residual_max = running_max;
        exp_res.last = 1'b0;
        expected_q.push_back(exp_res);
      end
      old_rows[cur_bank + c] = pt.grid_value;
      forcing_row[c] = pt.forcing;
      if (grid_end && r >= 1) begin
        exp_res.new_value = pt.grid_value;
        exp_res.residual_max = running_max;
        exp_res.last = row_end;
        expected_q.push_back(exp_res);
      end
      if (row_end) begin
        col_count = 0;
        row_count = grid_end ? 0 : r + 1;
      end else begin
        col_count = c + 1;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: value %h residual %h last %b",
                   got.new_value, got.residual_max, got.last);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.new_value !== want.new_value || got.residual_max !== want.residual_max ||
            got.last !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display("result mismatch: expected value %h residual %h last %b, got %h %h %b",
                     want.new_value, want.residual_max, want.last,
                     got.new_value, got.residual_max, got.last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t point_in;
  logic result_valid;
  logic result_stall;
  result_t point_out;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  bit idle_on;
  bit long_hold;
  int points_sent;
  int unsigned cycle_count = 0;
  sweep_scoreboard grid_model = new();

  poisson_stencil_sweep u_top (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(point_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(point_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) grid_model.check_result(point_out);
  end

  initial begin : result_backpressure
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic value_t rand_value(input bit is_forcing);
    if (is_forcing && $urandom_range(0, 3) == 0) return '0;
    case ($urandom_range(0, 11))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '0;
      3: return '1;
      4, 5: return value_t'($urandom_range(0, 1023)) - value_t'(512);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_point(input value_t grid_value, input value_t forcing);
    sample_t item;
    item.grid_value = grid_value;
    item.forcing = forcing;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    point_in <= item;
    do @(posedge clk); while (sample_stall);
    grid_model.note_point(item);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic finish_sweep();
    do send_point(rand_value(1'b0), rand_value(1'b1)); while (!grid_model.at_start());
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (grid_model.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    grid_model.write_config(index, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    value_t corner_grid[18];
    value_t corner_frc[18];
    logic [CFG_DATA_BITS-1:0] size;
    int base;
    rst = 1'b1;
    sample_valid = 1'b0;
    point_in = '0;
    cfg_write = 1'b0;
    cfg_index = REG_GRID_LAST_INDEX;
    cfg_data = '0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    points_sent = 0;
    corner_grid = '{VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MIN, VALUE_MAX,
                    '0, VALUE_MAX, '1,
                    VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MAX, VALUE_MIN,
                    '1, VALUE_MIN, '0};
    corner_frc = '{VALUE_MIN, '0, VALUE_MAX, '1, VALUE_MAX, '0, VALUE_MAX, VALUE_MIN, '0,
                   VALUE_MAX, '0, VALUE_MIN, '0, VALUE_MIN, VALUE_MAX, '1, '0, VALUE_MAX};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // smallest grid: positive saturation and a saturated change
    write_reg(REG_GRID_LAST_INDEX, 10'd0);
    for (int i = 0; i < 9; i++) send_point(corner_grid[i], corner_frc[i]);
    settle();
    // upper data bits are masked; residual tracking off
    write_reg(REG_METHOD, 10'h3FF);
    write_reg(REG_TRACK_RESIDUAL, 10'h3FE);
    write_reg(REG_UNUSED, 10'h3FF);
    write_reg(REG_GRID_LAST_INDEX, 10'd1);
    for (int i = 9; i < 18; i++) send_point(corner_grid[i], corner_frc[i]);
    settle();

    // fill the output queue while results are held off
    write_reg(REG_GRID_LAST_INDEX, 10'd9);
    write_reg(REG_TRACK_RESIDUAL, 10'd1);
    long_hold = 1'b1;
    finish_sweep();
    settle();

    // widest grid for part of a row, then shrink past the current column
    write_reg(REG_GRID_LAST_INDEX, 10'h3FF);
    write_reg(REG_METHOD, CFG_DATA_BITS'(METHOD_JACOBI));
    repeat (WIDE_POINTS) send_point(rand_value(1'b0), rand_value(1'b1));
    settle();
    write_reg(REG_GRID_LAST_INDEX, 10'd4);
    finish_sweep();
    settle();

    // shrink past the current row
    write_reg(REG_GRID_LAST_INDEX, 10'd8);
    write_reg(REG_METHOD, CFG_DATA_BITS'(METHOD_GAUSS_SEIDEL));
    repeat (38) send_point(rand_value(1'b0), rand_value(1'b1));
    settle();
    write_reg(REG_GRID_LAST_INDEX, 10'd3);
    finish_sweep();

    base = points_sent;
    while (points_sent - base < RANDOM_POINTS) begin
      settle();
      if ($urandom_range(0, 7) == 0) size = CFG_DATA_BITS'($urandom_range(10, 16));
      else size = CFG_DATA_BITS'($urandom_range(2, 9));
      write_reg(REG_GRID_LAST_INDEX, size);
      write_reg(REG_METHOD, CFG_DATA_BITS'($urandom));
      write_reg(REG_TRACK_RESIDUAL, CFG_DATA_BITS'($urandom));
      repeat ($urandom_range(1, 3)) begin
        idle_on = (points_sent - base) < CALM_POINTS;
        finish_sweep();
      end
    end

    settle();
    if (grid_model.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
